@@ sv/jqkr_pkg.sv @@
// Shared types and codes for the job queue with keyed removal.
// No dependencies; the entry store, sequencer, core and testbench import this package.
package jqkr_pkg;

    localparam int JOB_W    = 16;
    localparam int PROC_W   = 22;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // operation codes carried in the kind field
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_POP    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_FIND   = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_DONE = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SH_READ,
        ST_SH_WRITE,
        ST_DONE
    } state_t;

    // one stored queue entry
    typedef struct packed {
        logic [JOB_W-1:0]  job;
        logic [PROC_W-1:0] proc;
    } entry_t;

    // one finished result, handed from the sequencer to the output register
    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        entry_t             hit;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

@@ sv/jqkr_cmd_if.sv @@
// Command channel of the job queue: valid/ready handshake and command fields.
// Depends on nothing.
interface jqkr_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        match_by_job;
    logic [15:0] job_tag;
    logic [21:0] proc_id;

    modport source (output valid, kind, match_by_job, job_tag, proc_id, input ready);
    modport sink   (input valid, kind, match_by_job, job_tag, proc_id, output ready);
endinterface

@@ sv/jqkr_rsp_if.sv @@
// Result channel of the job queue: valid/ready handshake and result fields.
// Depends on nothing.
interface jqkr_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  position;
    logic [15:0] out_job_tag;
    logic [21:0] out_proc_id;
    logic [4:0]  count;

    modport source (output valid, status, position, out_job_tag, out_proc_id, count,
                    input ready);
    modport sink   (input valid, status, position, out_job_tag, out_proc_id, count,
                    output ready);
endinterface

@@ sv/jqkr_mem.sv @@
// Entry store of the job queue: one write port, one read port, registered read.
// Depends on jqkr_pkg for the entry type.
module jqkr_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  jqkr_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output jqkr_pkg::entry_t rd_data
);
    import jqkr_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/jqkr_ctrl.sv @@
// Sequencer of the job queue: takes a command, scans entries one at a time
// through a single key comparator, and closes gaps by moving entries forward.
// Depends on jqkr_pkg, jqkr_cmd_if and the entry store jqkr_mem.
module jqkr_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    jqkr_cmd_if.sink       cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output jqkr_pkg::res_t res
);
    import jqkr_pkg::*;

    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic                by_job_reg, by_job_next;
    logic [JOB_W-1:0]    key_job_reg, key_job_next;
    logic [PROC_W-1:0]   key_proc_reg, key_proc_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       sh_idx_reg, sh_idx_next;
    logic [CW-1:0]       count_reg, count_next;
    status_t             status_reg, status_next;
    entry_t              hit_reg, hit_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    entry_t              rd_data;

    kind_t               cmd_kind;
    logic [CW:0]         count_ext;
    logic [CW:0]         idx_p1;
    logic [CW:0]         sh_p1;
    logic [CW:0]         sh_p2;
    logic                full;
    logic                empty;
    logic                key_hit;
    logic                match;

    jqkr_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // index arithmetic and the shared key comparator
    assign cmd_kind  = kind_t'(cmd.kind);
    assign count_ext = (CW+1)'(count_reg);
    assign idx_p1    = (CW+1)'(idx_reg) + (CW+1)'(1);
    assign sh_p1     = (CW+1)'(sh_idx_reg) + (CW+1)'(1);
    assign sh_p2     = (CW+1)'(sh_idx_reg) + (CW+1)'(2);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign key_hit   = by_job_reg ? (rd_data.job == key_job_reg)
                                  : (rd_data.proc == key_proc_reg);
    assign match     = (kind_reg == KIND_POP) || key_hit;

    assign cmd.ready = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd_kind == KIND_INSERT || empty)
                        state_next = ST_DONE;
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (match)
                begin
                    if (kind_reg == KIND_FIND || !(idx_p1 < count_ext))
                        state_next = ST_DONE;
                    else
                        state_next = ST_SH_READ;
                end
                else if (idx_p1 < count_ext)
                    state_next = ST_READ;
                else
                    state_next = ST_DONE;
            end
            ST_SH_READ:
            begin
                state_next = ST_SH_WRITE;
            end
            ST_SH_WRITE:
            begin
                if (sh_p2 < count_ext)
                    state_next = ST_SH_READ;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath updates and store accesses
    always_comb
    begin
        kind_next     = kind_reg;
        by_job_next   = by_job_reg;
        key_job_next  = key_job_reg;
        key_proc_next = key_proc_reg;
        idx_next      = idx_reg;
        sh_idx_next   = sh_idx_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        hit_next      = hit_reg;
        wr_en         = 1'b0;
        wr_addr       = sh_idx_reg;
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        res_valid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next     = cmd_kind;
                    by_job_next   = cmd.match_by_job;
                    key_job_next  = cmd.job_tag;
                    key_proc_next = cmd.proc_id;
                    idx_next      = '0;
                    hit_next      = '0;
                    status_next   = STATUS_DONE;
                    if (cmd_kind == KIND_INSERT)
                    begin
                        if (full)
                            status_next = STATUS_FULL;
                        else
                        begin
                            // append at the tail
                            wr_en         = 1'b1;
                            wr_addr       = AW'(count_reg);
                            wr_data.job   = cmd.job_tag;
                            wr_data.proc  = cmd.proc_id;
                            idx_next      = AW'(count_reg);
                            hit_next.job  = cmd.job_tag;
                            hit_next.proc = cmd.proc_id;
                            count_next    = count_reg + CW'(1);
                        end
                    end
                    else if (empty)
                        status_next = STATUS_MISS;
                end
            end
            ST_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            ST_CHECK:
            begin
                if (match)
                begin
                    hit_next = rd_data;
                    if (kind_reg != KIND_FIND)
                    begin
                        if (idx_p1 < count_ext)
                            sh_idx_next = idx_reg;
                        else
                            count_next = count_reg - CW'(1);
                    end
                end
                else if (idx_p1 < count_ext)
                    idx_next = idx_reg + AW'(1);
                else
                begin
                    status_next = STATUS_MISS;
                    idx_next    = '0;
                end
            end
            ST_SH_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(sh_p1);
            end
            ST_SH_WRITE:
            begin
                // move the entry behind one place forward
                wr_en   = 1'b1;
                wr_addr = sh_idx_reg;
                wr_data = rd_data;
                if (sh_p2 < count_ext)
                    sh_idx_next = sh_idx_reg + AW'(1);
                else
                    count_next = count_reg - CW'(1);
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // result fields
    assign res.status   = status_reg;
    assign res.position = POS_W'(idx_reg);
    assign res.hit      = hit_reg;
    assign res.count    = COUNT_W'(count_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // command and scan registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        by_job_reg   <= by_job_next;
        key_job_reg  <= key_job_next;
        key_proc_reg <= key_proc_next;
        idx_reg      <= idx_next;
        sh_idx_reg   <= sh_idx_next;
        status_reg   <= status_next;
        hit_reg      <= hit_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> ((CW+1)'(idx_reg) < count_ext))
        else $error("scan index beyond last entry");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && cmd.valid && cmd_kind == KIND_INSERT && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the queue");

    a_shrink_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < $past(count_reg)) |-> (state_reg == ST_DONE))
        else $error("queue shrank before the item finished");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SH_READ) |-> (sh_p1 < count_ext))
        else $error("shift reads beyond last entry");
`endif

endmodule

@@ sv/job_queue_with_keyed_removal_core.sv @@
// Insert, and any command on an empty queue, go from the accepting state straight to the
// result state; pop, remove and find read and compare entries from the head up to a match
// (or all entries on a miss), then each entry behind a popped or removed one moves forward.
// One command in flight; every entry visited costs a registered store read
// followed by a compare or write state, which sets the pace. A finished result waits
// in an output register while the next command is taken. Reset clears the count; entries are not cleared.
module job_queue_with_keyed_removal_core #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    jqkr_cmd_if.sink  cmd,
    jqkr_rsp_if.source rsp
);
    import jqkr_pkg::*;

    logic   res_valid;
    logic   res_ready;
    res_t   res;

    logic   out_valid_reg, out_valid_next;
    res_t   out_data_reg;

    jqkr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    // result channel
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_data_reg.status;
    assign rsp.position    = out_data_reg.position;
    assign rsp.out_job_tag = out_data_reg.hit.job;
    assign rsp.out_proc_id = out_data_reg.hit.proc;
    assign rsp.count       = out_data_reg.count;

endmodule

@@ bench/job_queue_with_keyed_removal_core_tb.sv @@
// Testbench for job_queue_with_keyed_removal_core: directed and random job commands,
// checked against a queue predictor kept in step with every accepted command.
// Depends on jqkr_pkg, jqkr_cmd_if, jqkr_rsp_if and the core itself.
`timescale 1ns / 1ps

module job_queue_with_keyed_removal_core_tb;
    import jqkr_pkg::*;

    localparam int DEPTH      = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_OFF   = 300;

    logic clk;
    logic rst_n;

    jqkr_cmd_if cmd_ch ();
    jqkr_rsp_if rsp_ch ();

    job_queue_with_keyed_removal_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // predicted queue contents, updated at each accepted command
    entry_t jobs_model [DEPTH];
    int     jobs_len;

    // results still owed by the block, oldest first
    res_t   pending_results [$];
    res_t   want_res;

    int     mismatch_count;
    int     send_idle_pct;
    int     rsp_stall_pct;
    int     rsp_hold;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // apply one command to the predicted queue and return its result
    function automatic res_t apply_queue_op(kind_t k, logic by_job, logic [15:0] j,
                                            logic [21:0] p);
        res_t r;
        int   hit_idx;
        r = '0;
        r.status = STATUS_MISS;
        hit_idx = -1;
        case (k)
            KIND_INSERT:
            begin
                if (jobs_len >= DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    jobs_model[jobs_len] = '{job: j, proc: p};
                    r.status = STATUS_DONE;
                    r.position = 4'(jobs_len);
                    r.hit = jobs_model[jobs_len];
                    jobs_len++;
                end
            end
            KIND_POP:
            begin
                if (jobs_len > 0)
                    hit_idx = 0;
            end
            default:
            begin
                for (int i = 0; i < jobs_len && hit_idx < 0; i++)
                begin
                    if (by_job ? (jobs_model[i].job == j) : (jobs_model[i].proc == p))
                        hit_idx = i;
                end
            end
        endcase
        if (k != KIND_INSERT && hit_idx >= 0)
        begin
            r.status = STATUS_DONE;
            r.position = 4'(hit_idx);
            r.hit = jobs_model[hit_idx];
            // pop and remove close the gap behind the taken entry
            if (k != KIND_FIND)
            begin
                for (int i = hit_idx; i + 1 < jobs_len; i++)
                    jobs_model[i] = jobs_model[i + 1];
                jobs_len--;
            end
        end
        r.count = 5'(jobs_len);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // offer one item, with random sender gaps, until the block takes it
    task automatic send_cmd(input kind_t k, input logic by_job, input logic [15:0] j,
                            input logic [21:0] p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.kind         <= k;
        cmd_ch.match_by_job <= by_job;
        cmd_ch.job_tag      <= j;
        cmd_ch.proc_id      <= p;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        pending_results.push_back(apply_queue_op(k, by_job, j, p));
    endtask

    // drop valid and hold until every owed result has arrived
    task automatic wait_drain();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // one random command; remove and find keys mostly taken from the current queue contents
    task automatic random_cmd(input int insert_pct, output kind_t k, output logic by_job,
                              output logic [15:0] j, output logic [21:0] p);
        int pick;
        if ($urandom_range(99) < insert_pct)
            k = KIND_INSERT;
        else
            k = kind_t'($urandom_range(3, 1));
        by_job = 1'($urandom_range(1));
        j = 16'($urandom());
        p = 22'($urandom());
        // small key pools make duplicate entries likely
        if ($urandom_range(99) < 30)
            j = 16'($urandom_range(7));
        if ($urandom_range(99) < 30)
            p = 22'($urandom_range(7));
        if ((k == KIND_REMOVE || k == KIND_FIND) && jobs_len > 0
            && $urandom_range(99) < 75)
        begin
            pick = $urandom_range(jobs_len - 1);
            j = jobs_model[pick].job;
            p = jobs_model[pick].proc;
        end
    endtask

    // pop, remove and find on an empty queue
    task automatic test_empty_queue();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        send_cmd(KIND_POP, 1'b0, 16'h0000, 22'h000000);
        send_cmd(KIND_REMOVE, 1'b1, 16'hFFFF, 22'h3FFFFF);
        send_cmd(KIND_FIND, 1'b0, 16'h0000, 22'h3FFFFF);
        wait_drain();
    endtask

    // fill with extremes and duplicates, refuse when full, match nearest head
    task automatic test_full_queue();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        send_cmd(KIND_INSERT, 1'b0, 16'h0000, 22'h000000);
        send_cmd(KIND_INSERT, 1'b1, 16'hFFFF, 22'h3FFFFF);
        send_cmd(KIND_INSERT, 1'b0, 16'h0000, 22'h000005);
        for (int i = 3; i < DEPTH; i++)
            send_cmd(KIND_INSERT, 1'b0, 16'h1000 + 16'(i), 22'h200000 + 22'(i));
        send_cmd(KIND_INSERT, 1'b1, 16'h5A5A, 22'h15A5A5);
        send_cmd(KIND_FIND, 1'b1, 16'h0000, 22'h000000);
        send_cmd(KIND_FIND, 1'b0, 16'h0000, 22'h3FFFFF);
        send_cmd(KIND_FIND, 1'b1, 16'h7777, 22'h000000);
        send_cmd(KIND_REMOVE, 1'b0, 16'h0000, 22'h200000 + 22'(DEPTH - 1));
        send_cmd(KIND_REMOVE, 1'b1, 16'h0000, 22'h3FFFFF);
        send_cmd(KIND_REMOVE, 1'b0, 16'hFFFF, 22'h000000);
        send_cmd(KIND_POP, 1'b1, 16'h0000, 22'h000000);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int n_items, input int send_pct,
                                       input int stall_pct);
        kind_t       k;
        logic        by_job;
        logic [15:0] j;
        logic [21:0] p;
        int          insert_pct;
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
        insert_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            // swing the mix so the queue runs both full and empty
            if (i % 32 == 0)
            begin
                case ($urandom_range(2))
                    0:       insert_pct = 20;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            random_cmd(insert_pct, k, by_job, j, p);
            send_cmd(k, by_job, j, p);
        end
    endtask

    // long receiver hold-off while items keep coming, then a full drain
    task automatic test_backpressure();
        kind_t       k;
        logic        by_job;
        logic [15:0] j;
        logic [21:0] p;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        rsp_hold = HOLD_OFF;
        for (int i = 0; i < 10; i++)
        begin
            random_cmd(60, k, by_job, j, p);
            send_cmd(k, by_job, j, p);
        end
        wait_drain();
    endtask

    // receiver ready, with random stalls and counted hold-off
    always @(negedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, status", 32'(rsp_ch.status), 32'hx);
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (rsp_ch.status !== want_res.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want_res.status));
                if (rsp_ch.position !== want_res.position)
                    report_mismatch("position", 32'(rsp_ch.position),
                                    32'(want_res.position));
                if (rsp_ch.out_job_tag !== want_res.hit.job)
                    report_mismatch("out_job_tag", 32'(rsp_ch.out_job_tag),
                                    32'(want_res.hit.job));
                if (rsp_ch.out_proc_id !== want_res.hit.proc)
                    report_mismatch("out_proc_id", 32'(rsp_ch.out_proc_id),
                                    32'(want_res.hit.proc));
                if (rsp_ch.count !== want_res.count)
                    report_mismatch("count", 32'(rsp_ch.count), 32'(want_res.count));
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("job_queue_with_keyed_removal_core verification failed");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.kind         = KIND_INSERT;
        cmd_ch.match_by_job = 1'b0;
        cmd_ch.job_tag      = '0;
        cmd_ch.proc_id      = '0;
        rsp_ch.ready        = 1'b0;
        jobs_len            = 0;
        mismatch_count      = 0;
        send_idle_pct       = 0;
        rsp_stall_pct       = 0;
        rsp_hold            = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_full_queue();
        test_random_traffic(150, 0, 0);
        test_random_traffic(150, 88, 0);
        test_random_traffic(150, 0, 88);
        test_random_traffic(150, 34, 34);
        test_backpressure();
        test_random_traffic(60, 10, 10);

        wait_drain();
        repeat (40) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results left over, count", 32'(pending_results.size()), 0);
        if (mismatch_count == 0)
            $display("job_queue_with_keyed_removal_core verification clean");
        else
            $display("job_queue_with_keyed_removal_core verification failed");
        $finish;
    end

endmodule

@@ job_queue_with_keyed_removal_core.f @@
sv/jqkr_pkg.sv
sv/jqkr_cmd_if.sv
sv/jqkr_rsp_if.sv
sv/jqkr_mem.sv
sv/jqkr_ctrl.sv
sv/job_queue_with_keyed_removal_core.sv
bench/job_queue_with_keyed_removal_core_tb.sv
